FILE: rtl/spl_pkg.sv
// Package with shared types, constants and the key ordering function for the sorted list.
`default_nettype none
package spl_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_WIDTH = 32;
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_QUERY     = 2'd0,
      OP_PUSH      = 2'd1,
      OP_POP_FIRST = 2'd2,
      OP_POP_LAST  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT_LEFT
   } cell_action_type;

   typedef logic [KEY_WIDTH-1:0] key_type;

   typedef struct packed {
      opcode_type opcode;
      key_type    key_in;
   } req_type;

   typedef struct packed {
      key_type          popped_key;
      logic             success;
      key_type          first_key;
      key_type          last_key;
      logic [CNT_W-1:0] count;
      logic             empty_flag;
   } rsp_type;

   typedef struct packed {
      cell_action_type action;
      key_type         new_key;
      logic [1:0]      order_mode;
   } cell_ctrl_type;

   function automatic logic goes_after(key_type a, key_type b, logic [1:0] mode);
      key_type ta;
      key_type tb;
      ta = a;
      tb = b;
      if (mode[0]) begin
         ta[KEY_WIDTH-1] = ~ta[KEY_WIDTH-1];
         tb[KEY_WIDTH-1] = ~tb[KEY_WIDTH-1];
      end
      if (mode[1]) begin
         return ta < tb;
      end
      return ta > tb;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/sorted_priority_list_top.sv
// Top level of the sorted list: request control, row of slot cells, result register and CSR port.
// A request passes through the compare, update and report states before its result strobe.
// A new request is taken only in idle, after compare, shift update and result are done.
// The row of cells compares all slots at once and shifts them together; busy covers compare, update and report.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset clears the count, order mode and control; slot contents stay undefined until written.
`default_nettype none
module sorted_priority_list_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire spl_pkg::req_type req_data,
   output logic                  rsp_valid,
   output spl_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import spl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE,
      ST_REPORT
   } state_type;

   state_type        state_ff;
   opcode_type       op_ff;
   key_type          key_ff;
   logic [1:0]       mode_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CAPACITY-1:0] hit_ff;
   logic [CAPACITY-1:0] hit;
   logic [CAPACITY-1:0] hit_minus;
   logic [CAPACITY-1:0] first_pos;
   logic [CAPACITY-1:0] above_pos;
   logic [CAPACITY-1:0] occ;
   logic [CAPACITY-1:0] last_sel;
   key_type          slot_key [CAPACITY];
   key_type          last_mux;
   key_type          popped_ff;
   key_type          popped_in;
   logic             success_ff;
   logic             success_in;
   logic             full;
   cell_ctrl_type    ctrl;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_valid_ff;
   logic             csr_write;

   assign full = (count_ff == CNT_W'(CAPACITY));

   for (genvar i = 0; i < CAPACITY; i++) begin : g_occ
      assign occ[i] = (CNT_W'(i) < count_ff);
   end

   assign last_sel  = occ & ~(occ >> 1);
   assign hit_minus = hit_ff - CAPACITY'(1);
   assign first_pos = hit_ff & ~hit_minus;
   assign above_pos = ~(hit_ff ^ hit_minus);

   always_comb begin
      last_mux = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         last_mux = last_mux | (slot_key[i] & {KEY_WIDTH{last_sel[i]}});
      end
   end

   always_comb begin
      ctrl.action     = CELL_HOLD;
      ctrl.new_key    = key_ff;
      ctrl.order_mode = mode_ff;
      count_in        = count_ff;
      popped_in       = '0;
      success_in      = 1'b1;
      if (state_ff == ST_UPDATE) begin
         case (op_ff)
            OP_PUSH: begin
               if (full) begin
                  success_in = 1'b0;
               end else begin
                  ctrl.action = CELL_INSERT;
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            OP_POP_FIRST: begin
               if (count_ff == '0) begin
                  success_in = 1'b0;
               end else begin
                  ctrl.action = CELL_SHIFT_LEFT;
                  popped_in   = slot_key[0];
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            OP_POP_LAST: begin
               if (count_ff == '0) begin
                  success_in = 1'b0;
               end else begin
                  popped_in = last_mux;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            default: begin
               success_in = 1'b1;
            end
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type left_key;
      key_type right_key;
      if (i == 0) begin : g_first
         assign left_key = key_ff;
      end else begin : g_mid_l
         assign left_key = slot_key[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_key = slot_key[i];
      end else begin : g_mid_r
         assign right_key = slot_key[i+1];
      end
      spl_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .left_key  (left_key),
         .right_key (right_key),
         .occupied  (occ[i]),
         .at_pos    (first_pos[i]),
         .after_pos (above_pos[i]),
         .slot_key  (slot_key[i]),
         .hit       (hit[i])
      );
   end

   always_comb begin
      rsp_in.popped_key = popped_ff;
      rsp_in.success    = success_ff;
      rsp_in.first_key  = (count_ff != '0) ? slot_key[0] : '0;
      rsp_in.last_key   = (count_ff != '0) ? last_mux : '0;
      rsp_in.count      = count_ff;
      rsp_in.empty_flag = (count_ff == '0);
   end

   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mode_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= count_in;
         if (csr_write && (paddr[2] == 1'b0)) begin
            mode_ff <= pwdata[1:0];
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_COMPARE;
               end
            end
            ST_COMPARE: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               state_ff <= ST_REPORT;
            end
            ST_REPORT: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && start) begin
         op_ff  <= req_data.opcode;
         key_ff <= req_data.key_in;
      end
      if (state_ff == ST_COMPARE) begin
         hit_ff <= hit;
      end
      if (state_ff == ST_UPDATE) begin
         popped_ff  <= popped_in;
         success_ff <= success_in;
      end
      if (state_ff == ST_REPORT) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == 1'b0) ? {30'd0, mode_ff} : 32'd0;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored key count beyond capacity");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   a_rsp_after_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_REPORT))
      else $error("result strobe without a report cycle");

   a_empty_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.empty_flag == (rsp_data.count == '0)))
      else $error("empty flag disagrees with count");

endmodule
`default_nettype wire

FILE: rtl/spl_cell.sv
// One slot of the sorted list: holds a key, compares it and takes a neighbor's key on a shift.
`default_nettype none
module spl_cell (
   input  wire logic                   clock,
   input  wire spl_pkg::cell_ctrl_type ctrl,
   input  wire spl_pkg::key_type       left_key,
   input  wire spl_pkg::key_type       right_key,
   input  wire logic                   occupied,
   input  wire logic                   at_pos,
   input  wire logic                   after_pos,
   output spl_pkg::key_type            slot_key,
   output logic                        hit
);
   import spl_pkg::*;

   key_type slot_ff;
   key_type slot_in;

   always_comb begin
      hit = !occupied || !goes_after(ctrl.new_key, slot_ff, ctrl.order_mode);
   end

   always_comb begin
      slot_in = slot_ff;
      case (ctrl.action)
         CELL_INSERT: begin
            if (at_pos) begin
               slot_in = ctrl.new_key;
            end else if (after_pos) begin
               slot_in = left_key;
            end
         end
         CELL_SHIFT_LEFT: begin
            slot_in = right_key;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_key = slot_ff;

endmodule
`default_nettype wire

FILE: tb/tb_sorted_priority_list_top.sv
// Testbench for the sorted priority list: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module tb_sorted_priority_list_top;
   import spl_pkg::*;

   localparam logic [2:0] ADDR_ORDER_MODE = 3'd0;
   localparam logic [1:0] MODE_UNSIGNED_ASC  = 2'd0;
   localparam logic [1:0] MODE_SIGNED_ASC    = 2'd1;
   localparam logic [1:0] MODE_UNSIGNED_DESC = 2'd2;
   localparam logic [1:0] MODE_SIGNED_DESC   = 2'd3;

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        start   = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   key_type     stored_keys[$];
   logic [1:0]  sort_mode = MODE_UNSIGNED_ASC;
   rsp_type     pending_rsp_q[$];
   rsp_type     oldest_rsp;
   int          error_count = 0;
   bit          idle_en = 1'b1;

   sorted_priority_list_top u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit key_follows(key_type a, key_type b);
      key_type ta;
      key_type tb;
      ta = a;
      tb = b;
      ta[KEY_WIDTH-1] = ta[KEY_WIDTH-1] ^ sort_mode[0];
      tb[KEY_WIDTH-1] = tb[KEY_WIDTH-1] ^ sort_mode[0];
      return sort_mode[1] ? (ta < tb) : (ta > tb);
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type e;
      int      pos;
      e = '0;
      e.success = 1'b1;
      case (r.opcode)
         OP_PUSH: begin
            if (stored_keys.size() >= CAPACITY) begin
               e.success = 1'b0;
            end else begin
               pos = 0;
               while (pos < stored_keys.size() && key_follows(r.key_in, stored_keys[pos]))
                  pos++;
               stored_keys.insert(pos, r.key_in);
            end
         end
         OP_POP_FIRST: begin
            if (stored_keys.size() == 0) e.success = 1'b0;
            else e.popped_key = stored_keys.pop_front();
         end
         OP_POP_LAST: begin
            if (stored_keys.size() == 0) e.success = 1'b0;
            else e.popped_key = stored_keys.pop_back();
         end
         default: begin
         end
      endcase
      if (stored_keys.size() != 0) begin
         e.first_key = stored_keys[0];
         e.last_key  = stored_keys[stored_keys.size()-1];
      end
      e.count      = CNT_W'(stored_keys.size());
      e.empty_flag = (stored_keys.size() == 0);
      return e;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
            error_count++;
         end else begin
            oldest_rsp = pending_rsp_q.pop_front();
            check_field("popped_key", oldest_rsp.popped_key, rsp_data.popped_key);
            check_field("success", 32'(oldest_rsp.success), 32'(rsp_data.success));
            check_field("first_key", oldest_rsp.first_key, rsp_data.first_key);
            check_field("last_key", oldest_rsp.last_key, rsp_data.last_key);
            check_field("count", 32'(oldest_rsp.count), 32'(rsp_data.count));
            check_field("empty_flag", 32'(oldest_rsp.empty_flag), 32'(rsp_data.empty_flag));
         end
      end
   end

   task automatic issue_request(opcode_type op, key_type key);
      req_type r;
      r.opcode = op;
      r.key_in = key;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_rsp_q.push_back(apply_request(r));
      if (idle_en && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // hold off until every pending result has arrived and the block is idle
   task automatic wait_results();
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_order_mode(logic [1:0] m);
      logic [29:0] junk;
      logic [31:0] rd;
      junk = 30'($urandom);
      wait_results();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_ORDER_MODE;
      pwdata  <= {junk, m};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sort_mode = m;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      check_field("order_mode readback", {30'b0, m}, rd);
   endtask

   function automatic key_type rand_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $urandom_range(0, 7);
         6:          return key_type'($signed($urandom_range(0, 15)) - 8);
         7: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return '1;
               2:       return {1'b1, {(KEY_WIDTH-1){1'b0}}};
               default: return {1'b0, {(KEY_WIDTH-1){1'b1}}};
            endcase
         end
         default:    return $urandom | 32'h8000_0000;
      endcase
   endfunction

   task automatic test_empty_store();
      issue_request(OP_QUERY, $urandom);
      issue_request(OP_POP_FIRST, $urandom);
      issue_request(OP_POP_LAST, $urandom);
   endtask

   // leave two more keys stored after each mode round so later pushes meet an unsorted store
   task automatic test_order_modes();
      logic [1:0] modes[4];
      modes = '{MODE_UNSIGNED_ASC, MODE_SIGNED_ASC, MODE_UNSIGNED_DESC, MODE_SIGNED_DESC};
      foreach (modes[i]) begin
         set_order_mode(modes[i]);
         issue_request(OP_PUSH, 32'h0000_0000);
         issue_request(OP_PUSH, 32'hFFFF_FFFF);
         issue_request(OP_PUSH, 32'h8000_0000);
         issue_request(OP_PUSH, 32'h7FFF_FFFF);
         issue_request(OP_POP_FIRST, $urandom);
         issue_request(OP_POP_LAST, $urandom);
      end
   endtask

   task automatic test_tied_keys();
      issue_request(OP_PUSH, 32'h0000_0005);
      issue_request(OP_PUSH, 32'h0000_0005);
      issue_request(OP_PUSH, 32'h0000_0005);
      issue_request(OP_POP_FIRST, '0);
      issue_request(OP_QUERY, '0);
   endtask

   task automatic test_full_store();
      set_order_mode(MODE_SIGNED_ASC);
      while (stored_keys.size() < CAPACITY) issue_request(OP_PUSH, rand_key());
      issue_request(OP_PUSH, rand_key());
      issue_request(OP_PUSH, '1);
      issue_request(OP_QUERY, $urandom);
      issue_request(OP_POP_LAST, $urandom);
      issue_request(OP_PUSH, rand_key());
      while (stored_keys.size() > 0)
         issue_request($urandom_range(0, 1) ? OP_POP_FIRST : OP_POP_LAST, $urandom);
      issue_request(OP_POP_FIRST, $urandom);
      issue_request(OP_POP_LAST, $urandom);
   endtask

   task automatic random_phase(int n_items, int push_w, logic [1:0] m);
      int r;
      set_order_mode(m);
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 2) wait_results();
         r = $urandom_range(0, 99);
         if (r < push_w) issue_request(OP_PUSH, rand_key());
         else if (r < push_w + 8) issue_request(OP_QUERY, $urandom);
         else if (r % 2) issue_request(OP_POP_FIRST, $urandom);
         else issue_request(OP_POP_LAST, $urandom);
      end
   endtask

   task automatic test_random();
      logic [1:0] modes[8];
      modes = '{MODE_UNSIGNED_ASC, MODE_SIGNED_DESC, MODE_SIGNED_ASC, MODE_UNSIGNED_DESC,
                MODE_SIGNED_DESC, MODE_UNSIGNED_ASC, MODE_UNSIGNED_DESC, MODE_SIGNED_ASC};
      foreach (modes[i]) begin
         if (i >= 6) idle_en = 1'b0;
         random_phase(120, (i % 2 == 0) ? 75 : 30, modes[i]);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_order_modes();
      test_tied_keys();
      test_full_store();
      test_random();
      wait_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/spl_pkg.sv
rtl/spl_cell.sv
rtl/sorted_priority_list_top.sv
tb/tb_sorted_priority_list_top.sv
